FILE: hw/rtl/mchw_pkg.sv
// mchw_pkg: shared types, codes, reset values and decode helpers for the
// multi-channel health watchdog. No dependencies.
package mchw_pkg;

    // geometry
    localparam int NumCh     = 5;
    localparam int AgeBitsDef = 16;
    localparam int LimitW    = 16;
    localparam int CodeW     = 8;
    localparam int MvW       = 16;
    localparam int ActW      = 3;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    // channel slots
    localparam int ChHeart = 0;
    localparam int ChState = 1;
    localparam int ChBatt  = 2;
    localparam int ChOdom  = 3;
    localparam int ChAuto  = 4;

    // item actions
    localparam logic [ActW-1:0] ACT_TICK  = 3'd0;
    localparam logic [ActW-1:0] ACT_HEART = 3'd1;
    localparam logic [ActW-1:0] ACT_STATE = 3'd2;
    localparam logic [ActW-1:0] ACT_BATT  = 3'd3;
    localparam logic [ActW-1:0] ACT_ODOM  = 3'd4;
    localparam logic [ActW-1:0] ACT_AUTO  = 3'd5;
    localparam logic [ActW-1:0] ACT_CHECK = 3'd6;
    localparam logic [ActW-1:0] ACT_NONE  = 3'd7;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_SIM_MODE   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_HEART_LIM  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_STATE_LIM  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BATT_LIM   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ODOM_LIM   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_AUTO_LIM   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_WARN_MV    = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_ERROR_MV   = 3'd7;

    // reset values: 1 s, 2 s, 5 s, 3 s, 3 s at 1 ms ticks; 11.0 V and 10.5 V
    localparam logic [LimitW-1:0] RST_HEART_LIM = 16'd1000;
    localparam logic [LimitW-1:0] RST_STATE_LIM = 16'd2000;
    localparam logic [LimitW-1:0] RST_BATT_LIM  = 16'd5000;
    localparam logic [LimitW-1:0] RST_ODOM_LIM  = 16'd3000;
    localparam logic [LimitW-1:0] RST_AUTO_LIM  = 16'd3000;
    localparam logic [MvW-1:0]    RST_WARN_MV   = 16'd11000;
    localparam logic [MvW-1:0]    RST_ERROR_MV  = 16'd10500;

    typedef logic [2:0] t_level;

    localparam t_level LVL_OK    = 3'd0;
    localparam t_level LVL_WARN  = 3'd1;
    localparam t_level LVL_ERROR = 3'd2;
    localparam t_level LVL_WAIT  = 3'd3;
    localparam t_level LVL_OFF   = 3'd4;

    // lifecycle codes
    localparam logic [CodeW-1:0] LC_ACTIVE_A = 8'd4;
    localparam logic [CodeW-1:0] LC_ACTIVE_B = 8'd5;
    localparam logic [CodeW-1:0] LC_FAULT    = 8'd2;

    typedef struct packed {
        logic              sim_mode;
        logic [LimitW-1:0] heart_lim;
        logic [LimitW-1:0] state_lim;
        logic [LimitW-1:0] batt_lim;
        logic [LimitW-1:0] odom_lim;
        logic [LimitW-1:0] auto_lim;
        logic [MvW-1:0]    warn_mv;
        logic [MvW-1:0]    error_mv;
    } t_cfg;

    typedef struct packed {
        t_level     heart;
        t_level     state;
        t_level     batt;
        logic [1:0] odom;
        logic [1:0] auto_lvl;
        logic       ok;
    } t_result;

    function automatic t_level decode_state(input logic [CodeW-1:0] code);
        t_level lvl;
        unique case (code)
            LC_ACTIVE_A, LC_ACTIVE_B: lvl = LVL_OK;
            LC_FAULT:                 lvl = LVL_ERROR;
            default:                  lvl = LVL_WARN;
        endcase
        return lvl;
    endfunction

    // waiting when never seen, error when past the limit, else ok
    function automatic t_level live_level(input logic seen, input logic timed_out);
        t_level lvl;
        if (!seen) begin
            lvl = LVL_WAIT;
        end else if (timed_out) begin
            lvl = LVL_ERROR;
        end else begin
            lvl = LVL_OK;
        end
        return lvl;
    endfunction

endpackage

FILE: hw/rtl/mchw_cfg_regs.sv
// mchw_cfg_regs: configuration register bank, written through a plain port.
// Depends on mchw_pkg.
module mchw_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [mchw_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [mchw_pkg::CfgDataW-1:0] i_cfg_data,
    output mchw_pkg::t_cfg                o_cfg
);

    mchw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sim_mode  <= 1'b0;
            r_cfg.heart_lim <= mchw_pkg::RST_HEART_LIM;
            r_cfg.state_lim <= mchw_pkg::RST_STATE_LIM;
            r_cfg.batt_lim  <= mchw_pkg::RST_BATT_LIM;
            r_cfg.odom_lim  <= mchw_pkg::RST_ODOM_LIM;
            r_cfg.auto_lim  <= mchw_pkg::RST_AUTO_LIM;
            r_cfg.warn_mv   <= mchw_pkg::RST_WARN_MV;
            r_cfg.error_mv  <= mchw_pkg::RST_ERROR_MV;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mchw_pkg::REG_SIM_MODE:  r_cfg.sim_mode  <= i_cfg_data[0];
                mchw_pkg::REG_HEART_LIM: r_cfg.heart_lim <= i_cfg_data;
                mchw_pkg::REG_STATE_LIM: r_cfg.state_lim <= i_cfg_data;
                mchw_pkg::REG_BATT_LIM:  r_cfg.batt_lim  <= i_cfg_data;
                mchw_pkg::REG_ODOM_LIM:  r_cfg.odom_lim  <= i_cfg_data;
                mchw_pkg::REG_AUTO_LIM:  r_cfg.auto_lim  <= i_cfg_data;
                mchw_pkg::REG_WARN_MV:   r_cfg.warn_mv   <= i_cfg_data;
                mchw_pkg::REG_ERROR_MV:  r_cfg.error_mv  <= i_cfg_data;
                default:                 r_cfg.sim_mode  <= r_cfg.sim_mode;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/mchw_chan_state.sv
// mchw_chan_state: per-channel age counters, seen flags and last payloads.
// Depends on mchw_pkg.
module mchw_chan_state #(
    parameter int AGE_BITS = mchw_pkg::AgeBitsDef
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic [mchw_pkg::ActW-1:0]                  i_action,
    input  logic [mchw_pkg::CodeW-1:0]                 i_state_code,
    input  logic [mchw_pkg::MvW-1:0]                   i_voltage_mv,
    input  logic                                       i_sim_mode,
    output logic [mchw_pkg::NumCh-1:0][AGE_BITS-1:0]   o_age,
    output logic [mchw_pkg::NumCh-1:0]                 o_seen,
    output logic [mchw_pkg::CodeW-1:0]                 o_state_code,
    output logic [mchw_pkg::MvW-1:0]                   o_voltage_mv
);

    logic [mchw_pkg::NumCh-1:0][AGE_BITS-1:0] r_age, n_age;
    logic [mchw_pkg::NumCh-1:0]               r_seen, n_seen;
    logic [mchw_pkg::CodeW-1:0]               r_code, n_code;
    logic [mchw_pkg::MvW-1:0]                 r_mv, n_mv;
    logic [mchw_pkg::NumCh-1:0]               arrive;

    always_comb begin
        arrive = '0;
        n_code = r_code;
        n_mv   = r_mv;
        if (i_en) begin
            unique case (i_action)
                mchw_pkg::ACT_HEART: arrive[mchw_pkg::ChHeart] = !i_sim_mode;
                mchw_pkg::ACT_STATE: begin
                    arrive[mchw_pkg::ChState] = !i_sim_mode;
                    if (!i_sim_mode) n_code = i_state_code;
                end
                mchw_pkg::ACT_BATT: begin
                    arrive[mchw_pkg::ChBatt] = !i_sim_mode;
                    if (!i_sim_mode) n_mv = i_voltage_mv;
                end
                mchw_pkg::ACT_ODOM: arrive[mchw_pkg::ChOdom] = 1'b1;
                mchw_pkg::ACT_AUTO: arrive[mchw_pkg::ChAuto] = 1'b1;
                default:            arrive = '0;
            endcase
        end
    end

    always_comb begin
        for (int ch = 0; ch < mchw_pkg::NumCh; ch++) begin
            n_age[ch]  = r_age[ch];
            n_seen[ch] = r_seen[ch] | arrive[ch];
            if (arrive[ch]) begin
                n_age[ch] = '0;
            end else if (i_en && i_action == mchw_pkg::ACT_TICK && r_age[ch] != '1) begin
                n_age[ch] = r_age[ch] + AGE_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age  <= '0;
            r_seen <= '0;
            r_code <= '0;
            r_mv   <= '0;
        end else begin
            r_age  <= n_age;
            r_seen <= n_seen;
            r_code <= n_code;
            r_mv   <= n_mv;
        end
    end

    assign o_age        = r_age;
    assign o_seen       = r_seen;
    assign o_state_code = r_code;
    assign o_voltage_mv = r_mv;

endmodule

FILE: hw/rtl/mchw_eval.sv
// mchw_eval: combinational level and aggregate evaluation for a check.
// Depends on mchw_pkg.
module mchw_eval #(
    parameter int AGE_BITS = mchw_pkg::AgeBitsDef
) (
    input  logic [mchw_pkg::NumCh-1:0][AGE_BITS-1:0] i_age,
    input  logic [mchw_pkg::NumCh-1:0]               i_seen,
    input  logic [mchw_pkg::CodeW-1:0]               i_state_code,
    input  logic [mchw_pkg::MvW-1:0]                 i_voltage_mv,
    input  mchw_pkg::t_cfg                           i_cfg,
    output mchw_pkg::t_result                        o_result
);

    localparam int CmpW = (AGE_BITS > mchw_pkg::LimitW) ? AGE_BITS : mchw_pkg::LimitW;

    logic [mchw_pkg::NumCh-1:0][mchw_pkg::LimitW-1:0] limit;
    logic [mchw_pkg::NumCh-1:0]                       timed_out;
    mchw_pkg::t_level lv_heart, lv_state, lv_batt, lv_odom, lv_auto;
    logic ctrl_ok;

    always_comb begin
        limit[mchw_pkg::ChHeart] = i_cfg.heart_lim;
        limit[mchw_pkg::ChState] = i_cfg.state_lim;
        limit[mchw_pkg::ChBatt]  = i_cfg.batt_lim;
        limit[mchw_pkg::ChOdom]  = i_cfg.odom_lim;
        limit[mchw_pkg::ChAuto]  = i_cfg.auto_lim;
        for (int ch = 0; ch < mchw_pkg::NumCh; ch++) begin
            timed_out[ch] = CmpW'(i_age[ch]) > CmpW'(limit[ch]);
        end
    end

    always_comb begin
        lv_heart = mchw_pkg::live_level(i_seen[mchw_pkg::ChHeart], timed_out[mchw_pkg::ChHeart]);
        lv_state = mchw_pkg::live_level(i_seen[mchw_pkg::ChState], timed_out[mchw_pkg::ChState]);
        lv_batt  = mchw_pkg::live_level(i_seen[mchw_pkg::ChBatt], timed_out[mchw_pkg::ChBatt]);
        lv_odom  = mchw_pkg::live_level(i_seen[mchw_pkg::ChOdom], timed_out[mchw_pkg::ChOdom]);
        lv_auto  = mchw_pkg::live_level(i_seen[mchw_pkg::ChAuto], timed_out[mchw_pkg::ChAuto]);

        if (lv_state == mchw_pkg::LVL_OK) begin
            lv_state = mchw_pkg::decode_state(i_state_code);
        end
        if (lv_batt == mchw_pkg::LVL_OK) begin
            if (i_voltage_mv < i_cfg.error_mv) begin
                lv_batt = mchw_pkg::LVL_ERROR;
            end else if (i_voltage_mv < i_cfg.warn_mv) begin
                lv_batt = mchw_pkg::LVL_WARN;
            end
        end

        ctrl_ok = lv_heart == mchw_pkg::LVL_OK && lv_state == mchw_pkg::LVL_OK
               && lv_batt == mchw_pkg::LVL_OK;

        if (i_cfg.sim_mode) begin
            o_result.heart = mchw_pkg::LVL_OFF;
            o_result.state = mchw_pkg::LVL_OFF;
            o_result.batt  = mchw_pkg::LVL_OFF;
        end else begin
            o_result.heart = lv_heart;
            o_result.state = lv_state;
            o_result.batt  = lv_batt;
        end
        o_result.odom     = lv_odom[1:0];
        o_result.auto_lvl = lv_auto[1:0];
        o_result.ok       = (i_cfg.sim_mode || ctrl_ok)
                         && lv_odom != mchw_pkg::LVL_ERROR
                         && lv_auto != mchw_pkg::LVL_ERROR;
    end

endmodule

FILE: hw/rtl/multi_channel_health_watchdog_core.sv
// multi_channel_health_watchdog_core: top level of the health watchdog.
// Depends on mchw_pkg, mchw_cfg_regs, mchw_chan_state and mchw_eval.
//
// Watches five channels (heartbeat, controller state, battery, odometry,
// autonomy). Each input transfer is one event: a 1 ms tick that ages every
// channel (saturating at 2^AGE_BITS - 1), an arrival that clears one channel's
// age and marks it seen (state and battery arrivals also latch the lifecycle
// code or the millivolt reading), or a check that produces one result transfer
// with a level per channel and an overall ok bit. Every other event produces
// no result. The block takes one transfer per cycle while no check is held
// back: a transfer lands in an input register and is evaluated there against
// the channel state, and a check is loaded into the output register as soon as
// that register is free. Only a check sitting in the input register while the
// output register is full and not being taken holds the input side; ticks and
// arrivals always drain. Sim mode turns off
// heartbeat, state and battery monitoring (their arrivals are ignored, they
// report level 4). Configuration writes apply from the next cycle and are
// meant for when the block is idle.
module multi_channel_health_watchdog_core #(
    parameter int AGE_BITS = mchw_pkg::AgeBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [mchw_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [mchw_pkg::CfgDataW-1:0] i_cfg_data,

    // event channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mchw_pkg::ActW-1:0]     i_action,
    input  logic [mchw_pkg::CodeW-1:0]    i_state_code,
    input  logic [mchw_pkg::MvW-1:0]      i_voltage_mv,

    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_heartbeat_level,
    output logic [2:0]                    o_lifecycle_level,
    output logic [2:0]                    o_battery_level,
    output logic [1:0]                    o_odometry_level,
    output logic [1:0]                    o_autonomy_level,
    output logic                          o_system_ok
);

    mchw_pkg::t_cfg    cfg;
    mchw_pkg::t_result eval_res;

    logic [mchw_pkg::NumCh-1:0][AGE_BITS-1:0] age;
    logic [mchw_pkg::NumCh-1:0]               seen;
    logic [mchw_pkg::CodeW-1:0]               last_code;
    logic [mchw_pkg::MvW-1:0]                 last_mv;

    // input register
    logic                         r_in_valid;
    logic [mchw_pkg::ActW-1:0]    r_in_action;
    logic [mchw_pkg::CodeW-1:0]   r_in_code;
    logic [mchw_pkg::MvW-1:0]     r_in_mv;

    // result register
    logic                         r_out_valid;
    mchw_pkg::t_result            r_out;

    logic in_is_check;
    logic out_free;
    logic in_advance;
    logic in_take;
    logic out_load;

    assign in_is_check = r_in_action == mchw_pkg::ACT_CHECK;
    assign out_free    = !r_out_valid || i_ready;
    // a held item moves on unless it is a check with nowhere to go
    assign in_advance  = r_in_valid && (!in_is_check || out_free);
    assign o_ready     = !r_in_valid || in_advance;
    assign in_take     = i_valid && o_ready;
    assign out_load    = in_advance && in_is_check;

    mchw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mchw_chan_state #(
        .AGE_BITS (AGE_BITS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_advance),
        .i_action     (r_in_action),
        .i_state_code (r_in_code),
        .i_voltage_mv (r_in_mv),
        .i_sim_mode   (cfg.sim_mode),
        .o_age        (age),
        .o_seen       (seen),
        .o_state_code (last_code),
        .o_voltage_mv (last_mv)
    );

    // a check changes no channel state, so it reads the state as it stands
    mchw_eval #(
        .AGE_BITS (AGE_BITS)
    ) u_eval (
        .i_age        (age),
        .i_seen       (seen),
        .i_state_code (last_code),
        .i_voltage_mv (last_mv),
        .i_cfg        (cfg),
        .o_result     (eval_res)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_action;
            r_in_code   <= i_state_code;
            r_in_mv     <= i_voltage_mv;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= eval_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_heartbeat_level = r_out.heart;
    assign o_lifecycle_level = r_out.state;
    assign o_battery_level   = r_out.batt;
    assign o_odometry_level  = r_out.odom;
    assign o_autonomy_level  = r_out.auto_lvl;
    assign o_system_ok       = r_out.ok;

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for multi_channel_health_watchdog_core
// depends on mchw_pkg and the core rtl; runs directed rows, then randomized
// register phases checked against an in-bench health model
`timescale 1ns / 100ps

module tb;

    localparam int AGE_W          = mchw_pkg::AgeBitsDef;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 4;    // two-stage pipe plus margin
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;  // long receiver back-pressure window
    localparam int PHASES         = 7;
    localparam int ITEMS_PER_PHASE = 290;

    // 2-bit level codes for the liveness-only channels
    localparam logic [1:0] LIVE_OK    = 2'(mchw_pkg::LVL_OK);
    localparam logic [1:0] LIVE_ERROR = 2'(mchw_pkg::LVL_ERROR);
    localparam logic [1:0] LIVE_WAIT  = 2'(mchw_pkg::LVL_WAIT);

    // reports that can be read straight off the rules
    localparam mchw_pkg::t_result ALL_WAIT =
        '{mchw_pkg::LVL_WAIT, mchw_pkg::LVL_WAIT, mchw_pkg::LVL_WAIT,
          LIVE_WAIT, LIVE_WAIT, 1'b0};
    localparam mchw_pkg::t_result LIVE_ONLY =
        '{mchw_pkg::LVL_WAIT, mchw_pkg::LVL_WAIT, mchw_pkg::LVL_WAIT,
          LIVE_OK, LIVE_OK, 1'b0};
    localparam mchw_pkg::t_result ALL_OK =
        '{mchw_pkg::LVL_OK, mchw_pkg::LVL_OK, mchw_pkg::LVL_OK,
          LIVE_OK, LIVE_OK, 1'b1};
    localparam mchw_pkg::t_result STATE_FAULT =
        '{mchw_pkg::LVL_OK, mchw_pkg::LVL_ERROR, mchw_pkg::LVL_OK,
          LIVE_OK, LIVE_OK, 1'b0};
    localparam mchw_pkg::t_result BATT_LOW =
        '{mchw_pkg::LVL_OK, mchw_pkg::LVL_OK, mchw_pkg::LVL_ERROR,
          LIVE_OK, LIVE_OK, 1'b0};

    typedef struct packed {
        logic [mchw_pkg::ActW-1:0]  act;
        logic [mchw_pkg::CodeW-1:0] code;
        logic [mchw_pkg::MvW-1:0]   mv;
        bit                         pinned;   // report typed in below
        mchw_pkg::t_result          want;
    } t_row;

    typedef struct packed {
        bit                pinned;
        mchw_pkg::t_result want;
    } t_pin;

    // directed rows: empty channels, unused action, each arrival, lifecycle decode,
    // battery thresholds right at and just under the limits
    t_row directed_rows [22] = '{
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b1, ALL_WAIT},
        '{mchw_pkg::ACT_NONE,  8'hFF,                 16'hFFFF,  1'b0, '0},
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b1, ALL_WAIT},
        '{mchw_pkg::ACT_ODOM,  8'd0,                  16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_AUTO,  8'd0,                  16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b1, LIVE_ONLY},
        '{mchw_pkg::ACT_HEART, 8'd0,                  16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_STATE, mchw_pkg::LC_ACTIVE_A, 16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_BATT,  8'd0,                  16'd11000, 1'b0, '0},
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b1, ALL_OK},
        '{mchw_pkg::ACT_STATE, mchw_pkg::LC_FAULT,    16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b1, STATE_FAULT},
        '{mchw_pkg::ACT_STATE, 8'hFF,                 16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_STATE, mchw_pkg::LC_ACTIVE_B, 16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_BATT,  8'd0,                  16'd10499, 1'b0, '0},
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b1, BATT_LOW},
        '{mchw_pkg::ACT_BATT,  8'd0,                  16'd10999, 1'b0, '0},
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_BATT,  8'd0,                  16'hFFFF,  1'b0, '0},
        '{mchw_pkg::ACT_TICK,  8'd0,                  16'd0,     1'b0, '0},
        '{mchw_pkg::ACT_CHECK, 8'd0,                  16'd0,     1'b0, '0}
    };

    // dut ports, all known from time zero
    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_wr_en  = 1'b0;
    logic [mchw_pkg::CfgIdxW-1:0]  i_cfg_index  = mchw_pkg::REG_SIM_MODE;
    logic [mchw_pkg::CfgDataW-1:0] i_cfg_data   = '0;
    logic                          i_valid      = 1'b0;
    logic [mchw_pkg::ActW-1:0]     i_action     = mchw_pkg::ACT_TICK;
    logic [mchw_pkg::CodeW-1:0]    i_state_code = '0;
    logic [mchw_pkg::MvW-1:0]      i_voltage_mv = '0;
    logic                          i_ready      = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic [2:0]                    o_heartbeat_level;
    logic [2:0]                    o_lifecycle_level;
    logic [2:0]                    o_battery_level;
    logic [1:0]                    o_odometry_level;
    logic [1:0]                    o_autonomy_level;
    logic                          o_system_ok;

    // health model state, mirrors what the core should hold
    logic [AGE_W-1:0]           chan_age  [mchw_pkg::NumCh];
    logic                       chan_seen [mchw_pkg::NumCh];
    logic [mchw_pkg::CodeW-1:0] held_code;
    logic [mchw_pkg::MvW-1:0]   held_mv;
    mchw_pkg::t_cfg             cfg_shadow;

    mchw_pkg::t_result pending_reports [$];   // expected check reports, oldest first
    t_pin              pin_queue [$];         // one per check offered, in offer order

    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  tx_idle     = 1'b1;
    bit  rx_idle     = 1'b1;
    bit  rx_hold     = 1'b0;

    multi_channel_health_watchdog_core #(
        .AGE_BITS(AGE_W)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_action          (i_action),
        .i_state_code      (i_state_code),
        .i_voltage_mv      (i_voltage_mv),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_heartbeat_level (o_heartbeat_level),
        .o_lifecycle_level (o_lifecycle_level),
        .o_battery_level   (o_battery_level),
        .o_odometry_level  (o_odometry_level),
        .o_autonomy_level  (o_autonomy_level),
        .o_system_ok       (o_system_ok)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model

    function automatic void clear_model();
        for (int ch = 0; ch < mchw_pkg::NumCh; ch++) begin
            chan_age[ch]  = '0;
            chan_seen[ch] = 1'b0;
        end
        held_code  = '0;
        held_mv    = '0;
        cfg_shadow = '{1'b0, mchw_pkg::RST_HEART_LIM, mchw_pkg::RST_STATE_LIM,
                       mchw_pkg::RST_BATT_LIM, mchw_pkg::RST_ODOM_LIM,
                       mchw_pkg::RST_AUTO_LIM, mchw_pkg::RST_WARN_MV,
                       mchw_pkg::RST_ERROR_MV};
    endfunction

    function automatic void latch_reg(input logic [mchw_pkg::CfgIdxW-1:0] idx,
                                      input logic [mchw_pkg::CfgDataW-1:0] data);
        case (idx)
            mchw_pkg::REG_SIM_MODE:  cfg_shadow.sim_mode  = data[0];
            mchw_pkg::REG_HEART_LIM: cfg_shadow.heart_lim = data;
            mchw_pkg::REG_STATE_LIM: cfg_shadow.state_lim = data;
            mchw_pkg::REG_BATT_LIM:  cfg_shadow.batt_lim  = data;
            mchw_pkg::REG_ODOM_LIM:  cfg_shadow.odom_lim  = data;
            mchw_pkg::REG_AUTO_LIM:  cfg_shadow.auto_lim  = data;
            mchw_pkg::REG_WARN_MV:   cfg_shadow.warn_mv   = data;
            mchw_pkg::REG_ERROR_MV:  cfg_shadow.error_mv  = data;
        endcase
    endfunction

    function automatic void mark_arrival(input int ch);
        chan_age[ch]  = '0;
        chan_seen[ch] = 1'b1;
    endfunction

    // never seen -> waiting, strictly past its limit -> error
    function automatic mchw_pkg::t_level liveness(input int ch,
                                                  input logic [mchw_pkg::LimitW-1:0] limit);
        mchw_pkg::t_level lvl;
        lvl = mchw_pkg::LVL_OK;
        if (!chan_seen[ch]) begin
            lvl = mchw_pkg::LVL_WAIT;
        end else if (chan_age[ch] > limit) begin
            lvl = mchw_pkg::LVL_ERROR;
        end
        return lvl;
    endfunction

    // advance the model by one event; returns 1 when a report comes out
    function automatic bit health_update(input logic [mchw_pkg::ActW-1:0] act,
                                         input logic [mchw_pkg::CodeW-1:0] code,
                                         input logic [mchw_pkg::MvW-1:0] mv,
                                         output mchw_pkg::t_result rep);
        bit               report;
        mchw_pkg::t_level lc;
        mchw_pkg::t_level bt;
        mchw_pkg::t_level od;
        mchw_pkg::t_level au;
        report = 1'b0;
        rep    = '0;
        case (act)
            mchw_pkg::ACT_TICK: begin
                for (int ch = 0; ch < mchw_pkg::NumCh; ch++) begin
                    if (chan_age[ch] != '1) chan_age[ch] = chan_age[ch] + AGE_W'(1);
                end
            end
            mchw_pkg::ACT_HEART: begin
                if (!cfg_shadow.sim_mode) mark_arrival(mchw_pkg::ChHeart);
            end
            mchw_pkg::ACT_STATE: begin
                if (!cfg_shadow.sim_mode) begin
                    mark_arrival(mchw_pkg::ChState);
                    held_code = code;
                end
            end
            mchw_pkg::ACT_BATT: begin
                if (!cfg_shadow.sim_mode) begin
                    mark_arrival(mchw_pkg::ChBatt);
                    held_mv = mv;
                end
            end
            mchw_pkg::ACT_ODOM: mark_arrival(mchw_pkg::ChOdom);
            mchw_pkg::ACT_AUTO: mark_arrival(mchw_pkg::ChAuto);
            mchw_pkg::ACT_CHECK: begin
                report = 1'b1;
                rep.ok = 1'b1;
                if (cfg_shadow.sim_mode) begin
                    rep.heart = mchw_pkg::LVL_OFF;
                    rep.state = mchw_pkg::LVL_OFF;
                    rep.batt  = mchw_pkg::LVL_OFF;
                end else begin
                    rep.heart = liveness(mchw_pkg::ChHeart, cfg_shadow.heart_lim);
                    lc = liveness(mchw_pkg::ChState, cfg_shadow.state_lim);
                    if (lc == mchw_pkg::LVL_OK) begin
                        case (held_code)
                            mchw_pkg::LC_ACTIVE_A,
                            mchw_pkg::LC_ACTIVE_B: lc = mchw_pkg::LVL_OK;
                            mchw_pkg::LC_FAULT:    lc = mchw_pkg::LVL_ERROR;
                            default:               lc = mchw_pkg::LVL_WARN;
                        endcase
                    end
                    bt = liveness(mchw_pkg::ChBatt, cfg_shadow.batt_lim);
                    if (bt == mchw_pkg::LVL_OK) begin
                        if (held_mv < cfg_shadow.error_mv) begin
                            bt = mchw_pkg::LVL_ERROR;
                        end else if (held_mv < cfg_shadow.warn_mv) begin
                            bt = mchw_pkg::LVL_WARN;
                        end
                    end
                    rep.state = lc;
                    rep.batt  = bt;
                    if (rep.heart != mchw_pkg::LVL_OK || lc != mchw_pkg::LVL_OK
                        || bt != mchw_pkg::LVL_OK) rep.ok = 1'b0;
                end
                // odometry and autonomy fail only on timeout, waiting passes
                od = liveness(mchw_pkg::ChOdom, cfg_shadow.odom_lim);
                au = liveness(mchw_pkg::ChAuto, cfg_shadow.auto_lim);
                rep.odom     = od[1:0];
                rep.auto_lvl = au[1:0];
                if (rep.odom == LIVE_ERROR || rep.auto_lvl == LIVE_ERROR) rep.ok = 1'b0;
            end
            default: ;  // unused action code, nothing moves
        endcase
        return report;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------ monitor
    // samples both channels and the register port at each rising edge

    always @(posedge i_clk) begin
        mchw_pkg::t_result predicted;
        mchw_pkg::t_result want;
        mchw_pkg::t_result got;
        t_pin              pin;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_wr_en) latch_reg(i_cfg_index, i_cfg_data);
            // event transfer
            if (i_valid && o_ready) begin
                if (health_update(i_action, i_state_code, i_voltage_mv, predicted)) begin
                    pin  = pin_queue.pop_front();
                    want = pin.pinned ? pin.want : predicted;
                    pending_reports = {pending_reports, want};
                end
            end
            // report transfer
            if (o_valid && i_ready) begin
                got = '{o_heartbeat_level, o_lifecycle_level, o_battery_level,
                        o_odometry_level, o_autonomy_level, o_system_ok};
                if (pending_reports.size() == 0) begin
                    $error("report transfer with no report pending");
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("heartbeat_level", want.heart,    got.heart);
                    check_field("lifecycle_level", want.state,    got.state);
                    check_field("battery_level",   want.batt,     got.batt);
                    check_field("odometry_level",  want.odom,     got.odom);
                    check_field("autonomy_level",  want.auto_lvl, got.auto_lvl);
                    check_field("system_ok",       want.ok,       got.ok);
                end
            end
        end
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ----------------------------------------------------------- receiver
    // ready-high runs alternate with low bursts; one long hold on request

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                if (rx_idle) repeat ($urandom_range(0, 40)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------- sender

    // offer one event and hold it until the transfer happens
    task automatic offer(input logic [mchw_pkg::ActW-1:0] act,
                         input logic [mchw_pkg::CodeW-1:0] code,
                         input logic [mchw_pkg::MvW-1:0] mv, input bit pinned,
                         input mchw_pkg::t_result want);
        t_pin pin;
        pin.pinned = pinned;
        pin.want   = want;
        if (act == mchw_pkg::ACT_CHECK) pin_queue = {pin_queue, pin};
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_state_code <= code;
        i_voltage_mv <= mv;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic offer_random();
        logic [mchw_pkg::ActW-1:0]  act;
        logic [mchw_pkg::CodeW-1:0] code;
        logic [mchw_pkg::MvW-1:0]   mv;
        int unsigned                pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)      act = mchw_pkg::ACT_TICK;
        else if (pick < 43) act = mchw_pkg::ACT_HEART;
        else if (pick < 51) act = mchw_pkg::ACT_STATE;
        else if (pick < 59) act = mchw_pkg::ACT_BATT;
        else if (pick < 67) act = mchw_pkg::ACT_ODOM;
        else if (pick < 75) act = mchw_pkg::ACT_AUTO;
        else if (pick < 95) act = mchw_pkg::ACT_CHECK;
        else                act = mchw_pkg::ACT_NONE;
        // half the time codes 0 to 7, around the known lifecycle codes, else any byte
        code = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        // voltages hug the thresholds, sometimes anywhere
        case ($urandom_range(0, 2))
            0:       mv = cfg_shadow.error_mv + 16'($urandom_range(0, 4)) - 16'd2;
            1:       mv = cfg_shadow.warn_mv + 16'($urandom_range(0, 4)) - 16'd2;
            default: mv = 16'($urandom);
        endcase
        offer(act, code, mv, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [mchw_pkg::CfgIdxW-1:0] idx,
                             input logic [mchw_pkg::CfgDataW-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic sim, input logic [mchw_pkg::LimitW-1:0] lim [5],
                             input logic [mchw_pkg::MvW-1:0] warn,
                             input logic [mchw_pkg::MvW-1:0] err);
        write_reg(mchw_pkg::REG_SIM_MODE, {15'd0, sim});
        write_reg(mchw_pkg::REG_HEART_LIM, lim[0]);
        write_reg(mchw_pkg::REG_STATE_LIM, lim[1]);
        write_reg(mchw_pkg::REG_BATT_LIM,  lim[2]);
        write_reg(mchw_pkg::REG_ODOM_LIM,  lim[3]);
        write_reg(mchw_pkg::REG_AUTO_LIM,  lim[4]);
        write_reg(mchw_pkg::REG_WARN_MV,   warn);
        write_reg(mchw_pkg::REG_ERROR_MV,  err);
        i_cfg_wr_en <= 1'b0;
    endtask

    // stop offering, let every report come back, then let the pipe empty
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register settings per random phase, extremes in phases one and four
    task automatic program_phase(input int phase);
        logic [mchw_pkg::LimitW-1:0] lim [5];
        logic                        sim;
        logic [mchw_pkg::MvW-1:0]    warn;
        logic [mchw_pkg::MvW-1:0]    err;
        sim  = (phase == 2);
        warn = 16'($urandom);
        err  = 16'($urandom);
        for (int k = 0; k < 5; k++) lim[k] = 16'($urandom_range(0, 12));
        case (phase)
            1: begin
                for (int k = 0; k < 5; k++) lim[k] = '0;
                warn = '1;
                err  = '0;
            end
            4: begin
                for (int k = 0; k < 5; k++) lim[k] = '1;
                warn = '0;
                err  = '0;
            end
            5: begin
                warn = mchw_pkg::RST_WARN_MV;
                err  = mchw_pkg::RST_ERROR_MV;
            end
            default: ;
        endcase
        write_all(sim, lim, warn, err);
    endtask

    // --------------------------------------------------------------- main

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at reset settings
        foreach (directed_rows[r]) begin
            offer(directed_rows[r].act, directed_rows[r].code, directed_rows[r].mv,
                  directed_rows[r].pinned, directed_rows[r].want);
        end
        settle();

        // random phases under changing register settings
        for (int phase = 1; phase <= PHASES; phase++) begin
            program_phase(phase);
            tx_idle = (phase != PHASES) && ($urandom_range(0, 3) != 0);
            rx_idle = (phase != PHASES);
            if (phase == 5) begin
                // receiver stalls while checks keep coming, so the core backs up
                rx_hold = 1'b1;
                tx_idle = 1'b0;
                repeat (40) offer(mchw_pkg::ACT_CHECK, '0, '0, 1'b0, '0);
                tx_idle = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) offer_random();
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
